// ----- design/cmed_pkg.sv -----
// ----------------------------------------------------------------------------
// cmed_pkg
// shared widths, types and register codes for the colour matrix with
// error-diffusion dither
// ----------------------------------------------------------------------------
package cmed_pkg;

	// field and coefficient widths
	localparam int COEF_WIDTH   = 20;
	localparam int COEF_FRAC    = 8;
	localparam int IN_WIDTH     = 16;
	localparam int RES_FRAC     = 12;
	localparam int RES_WIDTH    = 24;
	localparam int PIX_WIDTH    = 8;
	localparam int ROW_WIDTH    = 60;
	localparam int NUM_COMP     = 3;

	// product and sum widths (coefficient times zero-extended input)
	localparam int PROD_WIDTH   = COEF_WIDTH + IN_WIDTH + 1;
	localparam int SUM_WIDTH    = PROD_WIDTH + 2;
	localparam int PROD_FRAC    = COEF_FRAC + IN_WIDTH - 1;

	// common alignment of sum and residual
	localparam int COMMON_FRAC  = (PROD_FRAC > RES_FRAC) ? PROD_FRAC : RES_FRAC;
	localparam int SUM_SHIFT    = COMMON_FRAC - PROD_FRAC;
	localparam int RES_SHIFT    = COMMON_FRAC - RES_FRAC;
	localparam int SUM_ALIGNED  = SUM_WIDTH + SUM_SHIFT;
	localparam int RES_ALIGNED  = RES_WIDTH + RES_SHIFT;
	localparam int CORR_WIDTH   = ((SUM_ALIGNED > RES_ALIGNED) ? SUM_ALIGNED : RES_ALIGNED) + 1;
	localparam int INT_WIDTH    = CORR_WIDTH - COMMON_FRAC;

	// rounding constants and limits
	localparam logic signed [CORR_WIDTH-1:0] ROUND_OUT = CORR_WIDTH'(1) << (COMMON_FRAC - 1);
	localparam logic signed [CORR_WIDTH-1:0] ROUND_RES = CORR_WIDTH'(1) << (RES_SHIFT - 1);
	localparam logic signed [CORR_WIDTH-1:0] RES_MAX   =
		CORR_WIDTH'((64'd1 << (RES_WIDTH - 1)) - 64'd1);
	localparam logic signed [CORR_WIDTH-1:0] RES_MIN   = -RES_MAX - CORR_WIDTH'(1);
	localparam logic [INT_WIDTH-1:0]         PIX_MAX   = INT_WIDTH'(255);

	typedef logic [IN_WIDTH-1:0]          comp_t;
	typedef logic [PIX_WIDTH-1:0]         pix_t;
	typedef logic [ROW_WIDTH-1:0]         row_t;
	typedef logic [1:0]                   cfg_idx_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [SUM_WIDTH-1:0]  sum_t;
	typedef logic signed [RES_WIDTH-1:0]  res_t;

	// configuration register indices
	typedef enum logic [1:0] {
		REG_RED_ROW   = 2'd0,
		REG_GREEN_ROW = 2'd1,
		REG_BLUE_ROW  = 2'd2
	} reg_idx_t;

	// pipeline advance controls shared by all lanes
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} lane_ctl_t;

endpackage

// ----- design/cmed_lane.sv -----
// ----------------------------------------------------------------------------
// cmed_lane
// one colour channel: three products, their sum, then residual add,
// rounding, clamping and the saturating residual update
// ----------------------------------------------------------------------------
module cmed_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  cmed_pkg::lane_ctl_t ctl,
	input  cmed_pkg::row_t      row,
	input  cmed_pkg::comp_t     x_value,
	input  cmed_pkg::comp_t     y_value,
	input  cmed_pkg::comp_t     z_value,
	output cmed_pkg::pix_t      pix
);
	import cmed_pkg::*;

	coef_t                        coef [NUM_COMP];
	logic signed [IN_WIDTH:0]     comp [NUM_COMP];
	prod_t                        prod_s1 [NUM_COMP];
	sum_t                         sum_s2;
	res_t                         res_q;
	pix_t                         pix_s3;
	logic signed [CORR_WIDTH-1:0] corr;
	logic signed [CORR_WIDTH-1:0] rnd;
	logic signed [CORR_WIDTH-1:0] diff;
	logic signed [CORR_WIDTH-1:0] res_rnd;
	logic [INT_WIDTH-1:0]         whole;
	pix_t                         pix_next;
	res_t                         res_next;

	// unpack coefficients, zero-extend the inputs
	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			coef[k] = coef_t'(row[k*COEF_WIDTH +: COEF_WIDTH]);
		end
		comp[0] = signed'({1'b0, x_value});
		comp[1] = signed'({1'b0, y_value});
		comp[2] = signed'({1'b0, z_value});
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				prod_s1[k] <= PROD_WIDTH'(coef[k] * comp[k]);
			end
		end
	end

	// stage 2: sum of products
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			sum_s2 <= SUM_WIDTH'(prod_s1[0]) + SUM_WIDTH'(prod_s1[1]) + SUM_WIDTH'(prod_s1[2]);
		end
	end

	// residual add, round half away from zero, clamp, new residual
	always_comb begin
		corr  = (CORR_WIDTH'(sum_s2) <<< SUM_SHIFT) + (CORR_WIDTH'(res_q) <<< RES_SHIFT);
		rnd   = corr + ROUND_OUT;
		whole = rnd[CORR_WIDTH-1:COMMON_FRAC];
		if (corr[CORR_WIDTH-1]) begin
			// any negative sum rounds to zero or below
			pix_next = '0;
		end else if (whole > PIX_MAX) begin
			pix_next = PIX_MAX[PIX_WIDTH-1:0];
		end else begin
			pix_next = whole[PIX_WIDTH-1:0];
		end
		diff    = corr - signed'(CORR_WIDTH'(pix_next) << COMMON_FRAC);
		res_rnd = (diff + ROUND_RES) >>> RES_SHIFT;
		if (res_rnd > RES_MAX) begin
			res_next = RES_MAX[RES_WIDTH-1:0];
		end else if (res_rnd < RES_MIN) begin
			res_next = RES_MIN[RES_WIDTH-1:0];
		end else begin
			res_next = res_rnd[RES_WIDTH-1:0];
		end
	end

	// residual persists from item to item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.load_s3) begin
			res_q <= res_next;
		end
	end

	// stage 3: output byte
	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			pix_s3 <= pix_next;
		end
	end

	assign pix = pix_s3;

endmodule

// ----- design/color_matrix_error_diffusion.sv -----
// ----------------------------------------------------------------------------
// color_matrix_error_diffusion
// XYZ to RGB8 matrix with per-channel error-diffusion dither
// ----------------------------------------------------------------------------
//  channel  signals                          direction  handshake
//  input    x_value y_value z_value          in         in_valid / in_stall
//  output   red green blue                   out        out_valid / out_stall
//  config   cfg_index cfg_data               in         cfg_valid / cfg_ready
//
//  one item per cycle sustained while out_stall is low, three register
//  stages (products, sum, residual loop); the residual add, round and
//  saturate close combinationally in the last stage, which sets the clock
//  each stage holds while the next is full and stalled, so empty stages
//  still take items while a result waits at the output
//  reset clears valids and residuals; coefficient rows reset to zero
//  config writes are always ready and take effect on the next item
// ----------------------------------------------------------------------------
module color_matrix_error_diffusion (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cmed_pkg::comp_t    x_value,
	input  cmed_pkg::comp_t    y_value,
	input  cmed_pkg::comp_t    z_value,
	output logic               out_valid,
	input  logic               out_stall,
	output cmed_pkg::pix_t     red,
	output cmed_pkg::pix_t     green,
	output cmed_pkg::pix_t     blue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  cmed_pkg::cfg_idx_t cfg_index,
	input  cmed_pkg::row_t     cfg_data
);
	import cmed_pkg::*;

	row_t      row_q [NUM_COMP];
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      adv_s1;
	logic      adv_s2;
	logic      adv_s3;
	lane_ctl_t ctl;
	pix_t      pix [NUM_COMP];

	// coefficient registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				row_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RED_ROW:   row_q[0] <= cfg_data;
				REG_GREEN_ROW: row_q[1] <= cfg_data;
				REG_BLUE_ROW:  row_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance: a stage moves when the next one is empty or moving
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	assign ctl.load_s1 = adv_s1;
	assign ctl.load_s2 = adv_s2;
	assign ctl.load_s3 = adv_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// one lane per colour channel
	for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
		cmed_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.row     (row_q[c]),
			.x_value (x_value),
			.y_value (y_value),
			.z_value (z_value),
			.pix     (pix[c])
		);
	end

	// merge lane bytes into the output item
	assign out_valid = valid_s3;
	assign red       = pix[0];
	assign green     = pix[1];
	assign blue      = pix[2];

endmodule
